### hdl/pic_pkg.sv
// Shared types and constants for the polymorphic inline cache.
package pic_pkg;

    localparam int TAG_W      = 32;
    localparam int DATA_W     = 16;
    localparam int COUNT_W    = 32;
    localparam int USED_W     = 3;
    localparam int IN_TDATA_W = 64;
    localparam int OUT_TDATA_W = 168;

    typedef enum logic [1:0] {
        CMD_LOOKUP  = 2'd0,
        CMD_UPDATE  = 2'd1,
        CMD_INV_ALL = 2'd2,
        CMD_INV_ONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_EMPTY = 2'd0,
        MODE_MONO  = 2'd1,
        MODE_POLY  = 2'd2
    } mode_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic compare;
        logic scan_step;
        logic apply;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

### hdl/pic_ctrl.sv
// Sequencer for the inline cache: capture, compare, LRU scan, apply.
module pic_ctrl
    import pic_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_SCAN,
        ST_APPLY
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_APPLY) && sts.out_free);
        cmd.capture   = s_tvalid && s_tready;
        cmd.compare   = (state_reg == ST_CMP);
        cmd.scan_step = (state_reg == ST_SCAN);
        cmd.apply     = (state_reg == ST_APPLY) && sts.out_free;

        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CMP;
            end
            ST_CMP: begin
                state_next = sts.need_scan ? ST_SCAN : ST_APPLY;
            end
            ST_SCAN: begin
                if (sts.scan_last) state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (sts.out_free) state_next = s_tvalid ? ST_CMP : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/pic_dpath.sv
// Entry store, tag compare, LRU scan, counters and result register.
module pic_dpath
    import pic_pkg::*;
#(
    parameter int ENTRIES = 4
)(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ctrl_cmd_t              cmd,
    output ctrl_sts_t              sts,
    input  logic [1:0]             s_tuser,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam bit HAS_SCAN = (ENTRIES > 1);

    // request word
    cmd_t              req_cmd_reg;
    logic [TAG_W-1:0]  req_tag_reg;
    logic [DATA_W-1:0] req_off_reg;
    logic [DATA_W-1:0] req_meth_reg;

    // entries
    logic [TAG_W-1:0]   entry_tag_reg    [ENTRIES];
    logic [DATA_W-1:0]  entry_offset_reg [ENTRIES];
    logic [DATA_W-1:0]  entry_method_reg [ENTRIES];
    logic [COUNT_W-1:0] entry_stamp_reg  [ENTRIES];
    logic [ENTRIES-1:0] entry_valid_reg;

    logic [COUNT_W-1:0] use_clock_reg, use_clock_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    mode_t              mode_reg, mode_next;
    logic [COUNT_W-1:0] lookup_reg, lookup_next;
    logic [COUNT_W-1:0] hits_reg, hits_next;
    logic [COUNT_W-1:0] miss_reg, miss_next;
    logic [COUNT_W-1:0] trans_reg, trans_next;

    // compare results
    logic               found_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    logic [DATA_W-1:0]  match_off_reg;
    logic [DATA_W-1:0]  match_meth_reg;

    // LRU scan
    logic [IDX_W-1:0]   scan_idx_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [COUNT_W-1:0] best_stamp_reg;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    // combinational match
    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] first_vec;
    logic               found_comb;
    logic [IDX_W-1:0]   match_idx_comb;
    logic [DATA_W-1:0]  match_off_comb;
    logic [DATA_W-1:0]  match_meth_comb;
    logic               full;

    // apply decode
    logic              wr_en;
    logic              wr_tag_en;
    logic [IDX_W-1:0]  wr_idx;
    logic              shift_en;
    logic              clear_all;
    logic              res_hit;
    logic [DATA_W-1:0] res_off;
    logic [DATA_W-1:0] res_meth;
    logic              res_is_meth;

    assign full = (occ_reg == OCC_W'(ENTRIES));

    always_comb begin
        found_comb      = 1'b0;
        match_idx_comb  = '0;
        match_off_comb  = '0;
        match_meth_comb = '0;
        first_vec       = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = entry_valid_reg[i] && (entry_tag_reg[i] == req_tag_reg);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                match_idx_comb = IDX_W'(i);
                first_vec      = '0;
                first_vec[i]   = 1'b1;
            end
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (first_vec[i]) begin
                match_off_comb  = match_off_comb  | entry_offset_reg[i];
                match_meth_comb = match_meth_comb | entry_method_reg[i];
            end
        end
        found_comb = |hit_vec;
    end

    always_comb begin
        sts.need_scan = HAS_SCAN && (req_cmd_reg == CMD_UPDATE) && !found_comb && full;
        sts.scan_last = (scan_idx_reg == IDX_W'(ENTRIES - 1));
        sts.out_free  = !out_valid_reg || m_tready;
    end

    // next state of the cache for the request in hand
    always_comb begin
        use_clock_next = use_clock_reg;
        occ_next       = occ_reg;
        mode_next      = mode_reg;
        lookup_next    = lookup_reg;
        hits_next      = hits_reg;
        miss_next      = miss_reg;
        trans_next     = trans_reg;
        wr_en          = 1'b0;
        wr_tag_en      = 1'b0;
        wr_idx         = match_idx_reg;
        shift_en       = 1'b0;
        clear_all      = 1'b0;
        res_hit        = 1'b0;
        res_off        = '0;
        res_meth       = '0;
        res_is_meth    = 1'b0;
        case (req_cmd_reg)
            CMD_LOOKUP: begin
                lookup_next = lookup_reg + 1'b1;
                if (found_reg) begin
                    hits_next      = hits_reg + 1'b1;
                    use_clock_next = use_clock_reg + 1'b1;
                    res_hit        = 1'b1;
                    res_off        = match_off_reg;
                    res_meth       = match_meth_reg;
                    res_is_meth    = (match_meth_reg != '0);
                end else begin
                    miss_next = miss_reg + 1'b1;
                end
            end
            CMD_UPDATE: begin
                use_clock_next = use_clock_reg + 1'b1;
                wr_en          = 1'b1;
                if (!found_reg) begin
                    wr_tag_en = 1'b1;
                    if (!full) begin
                        wr_idx   = occ_reg[IDX_W-1:0];
                        occ_next = occ_reg + 1'b1;
                    end else begin
                        wr_idx = best_idx_reg;
                    end
                    mode_next = (occ_next == OCC_W'(1)) ? MODE_MONO : MODE_POLY;
                    if (mode_next != mode_reg) trans_next = trans_reg + 1'b1;
                end
            end
            CMD_INV_ALL: begin
                clear_all  = 1'b1;
                occ_next   = '0;
                mode_next  = MODE_EMPTY;
                trans_next = trans_reg + 1'b1;
            end
            CMD_INV_ONE: begin
                if (found_reg) begin
                    shift_en   = 1'b1;
                    occ_next   = occ_reg - 1'b1;
                    trans_next = trans_reg + 1'b1;
                    if (occ_next == '0) begin
                        mode_next = MODE_EMPTY;
                    end else if (occ_next == OCC_W'(1)) begin
                        mode_next = MODE_MONO;
                    end else begin
                        mode_next = MODE_POLY;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            use_clock_reg   <= '0;
            occ_reg         <= '0;
            mode_reg        <= MODE_EMPTY;
            lookup_reg      <= '0;
            hits_reg        <= '0;
            miss_reg        <= '0;
            trans_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cmd.apply) begin
                use_clock_reg <= use_clock_next;
                occ_reg       <= occ_next;
                mode_reg      <= mode_next;
                lookup_reg    <= lookup_next;
                hits_reg      <= hits_next;
                miss_reg      <= miss_next;
                trans_reg     <= trans_next;
                if (clear_all) begin
                    entry_valid_reg <= '0;
                end else if (shift_en) begin
                    for (int i = 0; i < ENTRIES - 1; i++) begin
                        if (IDX_W'(i) >= match_idx_reg) begin
                            entry_valid_reg[i] <= entry_valid_reg[i+1];
                        end
                    end
                    entry_valid_reg[ENTRIES-1] <= 1'b0;
                end else if (wr_tag_en) begin
                    entry_valid_reg[wr_idx] <= 1'b1;
                end
            end
            if (cmd.apply) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_cmd_reg  <= cmd_t'(s_tuser);
            req_tag_reg  <= s_tdata[31:0];
            req_off_reg  <= s_tdata[47:32];
            req_meth_reg <= s_tdata[63:48];
        end
        if (cmd.compare) begin
            found_reg      <= found_comb;
            match_idx_reg  <= match_idx_comb;
            match_off_reg  <= match_off_comb;
            match_meth_reg <= match_meth_comb;
            scan_idx_reg   <= IDX_W'(1);
            best_idx_reg   <= '0;
            best_stamp_reg <= entry_stamp_reg[0];
        end
        if (cmd.scan_step) begin
            if (entry_stamp_reg[scan_idx_reg] < best_stamp_reg) begin
                best_idx_reg   <= scan_idx_reg;
                best_stamp_reg <= entry_stamp_reg[scan_idx_reg];
            end
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        if (cmd.apply) begin
            if (shift_en) begin
                for (int i = 0; i < ENTRIES - 1; i++) begin
                    if (IDX_W'(i) >= match_idx_reg) begin
                        entry_tag_reg[i]    <= entry_tag_reg[i+1];
                        entry_offset_reg[i] <= entry_offset_reg[i+1];
                        entry_method_reg[i] <= entry_method_reg[i+1];
                        entry_stamp_reg[i]  <= entry_stamp_reg[i+1];
                    end
                end
            end else if (wr_en) begin
                entry_offset_reg[wr_idx] <= req_off_reg;
                entry_method_reg[wr_idx] <= req_meth_reg;
                entry_stamp_reg[wr_idx]  <= use_clock_next;
                if (wr_tag_en) entry_tag_reg[wr_idx] <= req_tag_reg;
            end else if (res_hit) begin
                entry_stamp_reg[match_idx_reg] <= use_clock_next;
            end
            out_data_reg <= {1'b0, trans_next, miss_next, hits_next, lookup_next,
                             USED_W'(occ_next), mode_next, res_is_meth,
                             res_meth, res_off, res_hit};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### hdl/polymorphic_inline_cache_unit.sv
// Polymorphic inline cache: top level with stream ports and checks.
//
// Usage:
//   s_ channel carries one request word: s_tuser is the command (lookup,
//   update, invalidate all, invalidate one shape); s_tdata holds the shape
//   tag, property offset and method handle. m_ channel returns exactly one
//   result word per request, in request order.
//   Sequence: a request is captured, compared into the match registers
//   and then applied, which registers its result word and raises
//   m_tvalid. An update that misses while all ENTRIES slots are occupied
//   first runs the LRU search, which walks the stamps one slot per cycle.
//   Overlap: the next request is taken in the apply cycle, so a new
//   request enters while the last one's result is being registered; no
//   request is taken during compare or search.
//   Stall: the result register holds its word while m_tready is low; the
//   block then stays in its apply step and drops s_tready until the word
//   is taken. Nothing is lost or duplicated.
//   Reset (aresetn low, synchronous): all entries invalid, occupancy 0,
//   mode empty, use clock and all four counters cleared, no result held.
module polymorphic_inline_cache_unit
    import pic_pkg::*;
#(
    parameter int ENTRIES = 4
)(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tuser: command[1:0]
    input  logic [1:0]             s_tuser,
    // tdata: shape_tag[31:0], prop_offset[47:32], method_handle[63:48]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tdata: hit[0], hit_offset[16:1], hit_method[32:17], is_method[33],
    // cache_mode[35:34], used_entries[38:36], lookup_total[70:39],
    // hit_total[102:71], miss_total[134:103], transition_total[166:135],
    // zero pad[167]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    ctrl_cmd_t ctrl_cmd;
    ctrl_sts_t ctrl_sts;

    pic_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (ctrl_sts),
        .cmd      (ctrl_cmd)
    );

    pic_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (ctrl_cmd),
        .sts      (ctrl_sts),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A taken request always needs a compare cycle before the next one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted during compare");

    // Every lookup is either a hit or a miss.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[102:71] + m_tdata[134:103] == m_tdata[70:39]))
        else $error("hit and miss totals do not add up to lookups");

    // Result fields of a miss or a non-lookup are zero; is_method follows the handle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] ? (m_tdata[33] == (m_tdata[32:17] != 16'd0))
                                 : (m_tdata[33:1] == 33'd0)))
        else $error("hit payload inconsistent");

    // Mode agrees with occupancy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((ENTRIES > 7) ||
                      ((m_tdata[38:36] == 3'd0) == (m_tdata[35:34] == MODE_EMPTY) &&
                       (m_tdata[38:36] == 3'd1) == (m_tdata[35:34] == MODE_MONO))))
        else $error("cache mode does not match occupancy");

endmodule
